@@ rtl/core/cialt_pkg.sv @@
// Shared types, codes and helpers for the card identifier allow-list table.
package cialt_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int ID_BYTES_DEF    = 10;
   localparam int UID_W           = 80;   // full identifier field width (10 bytes)
   localparam int UID_BYTES       = UID_W / 8;

   typedef enum logic [2:0] {
      OP_LOOKUP = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      WHY_NONE      = 3'd0,
      WHY_NOT_FOUND = 3'd1,
      WHY_FULL      = 3'd2,
      WHY_PRESENT   = 3'd3,
      WHY_RANGE     = 3'd4
   } why_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_PEND
   } st_type;

   // request controls broadcast to every cell during a walk
   typedef struct packed {
      op_type op;
      logic   len_ok;
   } ctl_type;

   // token link between neighboring cells
   typedef struct packed {
      logic tok;
      logic hit;
   } link_type;

   // keeps bytes below len, byte 0 in the top bits
   function automatic logic [UID_W-1:0] key_mask(input logic [3:0] len);
      logic [UID_W-1:0] m;
      m = '0;
      for (int b = 0; b < UID_BYTES; b++) begin
         if (4'(b) < len) begin
            m[UID_W-1-8*b -: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

@@ rtl/core/card_id_allow_list_table_core.sv @@
// Top level of the card identifier allow-list table: cell chain, sequencer and result register.
//
// The table is a row of MAX_ENTRIES cells, one entry per cell, kept compact
// (entries 0 to count-1 are live). A request is taken when req_valid is high
// and req_stall is low; its key is masked to uid_len bytes and registered,
// then a token walks the cell chain one cell per clock. Each cell compares
// its entry with the key as the token passes and forwards a running hit flag;
// on delete every cell at or past the first match copies its upper neighbor,
// on insert the cell at index count captures the key when no earlier cell hit,
// and on read the cell at entry_index drops its entry onto the token. When
// the token leaves the chain tail, the result is registered in a pending
// register and then moves to the response register once it is free. The
// block takes the next request while a finished response still waits on
// rsp_stall; req stays stalled through a walk and while a finished result
// waits for the response register to free up. Entries beyond count hold no
// defined value and are never reported. Every response carries the count
// after its request; read fields are zero except on a successful read.
// Request types 5 to 7 return success 0, reason 0.
module card_id_allow_list_table_core
   import cialt_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int ID_BYTES    = ID_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_uid_len,
   input  logic [63:0] req_uid_lower,
   input  logic [15:0] req_uid_upper,
   input  logic [3:0]  req_entry_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_success,
   output logic [2:0]  rsp_reason,
   output logic [4:0]  rsp_entry_count,
   output logic [3:0]  rsp_read_len,
   output logic [63:0] rsp_read_lower,
   output logic [15:0] rsp_read_upper
);

   localparam int ID_W  = 8 * ID_BYTES;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   // sequencer
   st_type state_ff, state_in;
   logic   accept, rsp_free, pend_load, rsp_load;

   // registered request
   ctl_type          ctl_ff;
   logic [ID_W-1:0]  key_ff;
   logic [3:0]       len_ff;
   logic [3:0]       idx_ff;
   logic [CNT_W-1:0] count_ff;

   logic [UID_W-1:0] key_full;

   // chain wiring
   link_type         link [0:MAX_ENTRIES];
   logic [3:0]       rd_len [0:MAX_ENTRIES];
   logic [ID_W-1:0]  rd_id [0:MAX_ENTRIES];
   logic [3:0]       own_len [0:MAX_ENTRIES-1];
   logic [ID_W-1:0]  own_id [0:MAX_ENTRIES-1];
   logic [MAX_ENTRIES-1:0] tok_vec;

   // result at end of walk
   logic             res_ok;
   why_type          res_why;
   logic [CNT_W-1:0] res_count;
   logic [3:0]       res_rd_len;
   logic [UID_W-1:0] res_rd;

   // pending result and response register
   logic             pend_ok_ff, rsp_ok_ff;
   why_type          pend_why_ff, rsp_why_ff;
   logic [CNT_W-1:0] pend_count_ff, rsp_count_ff;
   logic [3:0]       pend_rd_len_ff, rsp_rd_len_ff;
   logic [UID_W-1:0] pend_rd_ff, rsp_rd_ff;
   logic             rsp_valid_ff;

   // ---------------- sequencer ----------------
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_WALK;
         ST_WALK: if (link[MAX_ENTRIES].tok) state_in = ST_PEND;
         ST_PEND: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      pend_load = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_WALK: pend_load = link[MAX_ENTRIES].tok;
         ST_PEND: rsp_load  = rsp_free;
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- request capture ----------------
   assign key_full = {req_uid_lower, req_uid_upper} & key_mask(req_uid_len);

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff.op     <= op_type'(req_type);
         ctl_ff.len_ok <= (req_uid_len != 4'd0) && (req_uid_len <= 4'(ID_BYTES));
         key_ff        <= key_full[UID_W-1 -: ID_W];
         len_ff        <= req_uid_len;
         idx_ff        <= req_entry_index;
      end
   end

   // ---------------- cell chain ----------------
   // token enters cell 0 on the accept edge
   assign link[0].tok = accept;
   assign link[0].hit = 1'b0;
   assign rd_len[0]   = '0;
   assign rd_id[0]    = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [3:0]      nxt_len;
      logic [ID_W-1:0] nxt_id;

      if (i < MAX_ENTRIES - 1) begin : g_mid
         assign nxt_len = own_len[i+1];
         assign nxt_id  = own_id[i+1];
      end else begin : g_last
         assign nxt_len = own_len[i];
         assign nxt_id  = own_id[i];
      end

      cialt_cell #(
         .IDX   (i),
         .ID_W  (ID_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl_ff),
         .key        (key_ff),
         .len        (len_ff),
         .idx        (idx_ff),
         .count      (count_ff),
         .link_in    (link[i]),
         .rd_len_in  (rd_len[i]),
         .rd_id_in   (rd_id[i]),
         .nxt_len    (nxt_len),
         .nxt_id     (nxt_id),
         .link_out   (link[i+1]),
         .rd_len_out (rd_len[i+1]),
         .rd_id_out  (rd_id[i+1]),
         .own_len    (own_len[i]),
         .own_id     (own_id[i])
      );

      assign tok_vec[i] = link[i+1].tok;
   end

   // ---------------- result decode at the chain tail ----------------
   always_comb begin
      res_ok     = 1'b0;
      res_why    = WHY_NONE;
      res_count  = count_ff;
      res_rd_len = '0;
      res_rd     = '0;
      unique case (ctl_ff.op)
         OP_LOOKUP: begin
            if (link[MAX_ENTRIES].hit) res_ok = 1'b1;
            else res_why = WHY_NOT_FOUND;
         end
         OP_INSERT: begin
            if (!ctl_ff.len_ok) begin
               res_why = WHY_NOT_FOUND;
            end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
               res_why = WHY_FULL;
            end else if (link[MAX_ENTRIES].hit) begin
               res_why = WHY_PRESENT;
            end else begin
               res_ok    = 1'b1;
               res_count = count_ff + 1'b1;
            end
         end
         OP_DELETE: begin
            if (link[MAX_ENTRIES].hit) begin
               res_ok    = 1'b1;
               res_count = count_ff - 1'b1;
            end else begin
               res_why = WHY_NOT_FOUND;
            end
         end
         OP_CLEAR: begin
            res_ok    = 1'b1;
            res_count = '0;
         end
         OP_READ: begin
            if (CMP_W'(idx_ff) < CMP_W'(count_ff)) begin
               res_ok                  = 1'b1;
               res_rd_len              = rd_len[MAX_ENTRIES];
               res_rd[UID_W-1 -: ID_W] = rd_id[MAX_ENTRIES];
            end else begin
               res_why = WHY_RANGE;
            end
         end
         default: res_ok = 1'b0;   // unknown request type: no effect
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (pend_load) begin
         count_ff <= res_count;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_load) begin
         pend_ok_ff     <= res_ok;
         pend_why_ff    <= res_why;
         pend_count_ff  <= res_count;
         pend_rd_len_ff <= res_rd_len;
         pend_rd_ff     <= res_rd;
      end
      if (rsp_load) begin
         rsp_ok_ff     <= pend_ok_ff;
         rsp_why_ff    <= pend_why_ff;
         rsp_count_ff  <= pend_count_ff;
         rsp_rd_len_ff <= pend_rd_len_ff;
         rsp_rd_ff     <= pend_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = rsp_ok_ff;
   assign rsp_reason      = rsp_why_ff;
   assign rsp_entry_count = 5'(rsp_count_ff);
   assign rsp_read_len    = rsp_rd_len_ff;
   assign rsp_read_lower  = rsp_rd_ff[UID_W-1 -: 64];
   assign rsp_read_upper  = rsp_rd_ff[15:0];

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one token in the cell chain");

   a_tail_in_walk: assert property (@(posedge clock) disable iff (reset)
      link[MAX_ENTRIES].tok |-> state_ff == ST_WALK)
      else $error("chain tail token outside a walk");

   a_accept_walk: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_WALK && link[1].tok)
      else $error("accepted request did not start a walk");

   a_pend_then_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("pending result not moved to response register");
`endif

endmodule

@@ rtl/core/cialt_cell.sv @@
// One table slot: holds an entry and passes the search token to its neighbor.
module cialt_cell
   import cialt_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int ID_W  = 80,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  ctl_type          ctl,
   input  logic [ID_W-1:0]  key,
   input  logic [3:0]       len,
   input  logic [3:0]       idx,
   input  logic [CNT_W-1:0] count,
   input  link_type         link_in,
   input  logic [3:0]       rd_len_in,
   input  logic [ID_W-1:0]  rd_id_in,
   input  logic [3:0]       nxt_len,
   input  logic [ID_W-1:0]  nxt_id,
   output link_type         link_out,
   output logic [3:0]       rd_len_out,
   output logic [ID_W-1:0]  rd_id_out,
   output logic [3:0]       own_len,
   output logic [ID_W-1:0]  own_id
);

   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
   localparam logic [CMP_W-1:0] MY_POS = CMP_W'(IDX);

   logic            tok_ff;
   logic            hit_ff;
   logic [3:0]      rd_len_ff;
   logic [ID_W-1:0] rd_id_ff;
   logic [3:0]      len_ff, len_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic            live, sel_rd, at_end, match, hit_now;

   assign live    = MY_POS < CMP_W'(count);
   assign sel_rd  = MY_POS == CMP_W'(idx);
   assign at_end  = MY_POS == CMP_W'(count);
   assign match   = tok_ff && live && ctl.len_ok && (len_ff == len) && (id_ff == key);
   assign hit_now = hit_ff || match;

   always_comb begin
      id_in  = id_ff;
      len_in = len_ff;
      if (tok_ff && ctl.op == OP_INSERT && ctl.len_ok && !hit_ff && at_end) begin
         id_in  = key;
         len_in = len;
      end else if (tok_ff && ctl.op == OP_DELETE && hit_now) begin
         // at or past the deleted slot: pull the entry from the next cell
         id_in  = nxt_id;
         len_in = nxt_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= link_in.tok;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff    <= link_in.hit;
      rd_len_ff <= rd_len_in;
      rd_id_ff  <= rd_id_in;
      id_ff     <= id_in;
      len_ff    <= len_in;
   end

   always_comb begin
      link_out.tok = tok_ff;
      link_out.hit = hit_now;
      if (tok_ff && ctl.op == OP_READ && sel_rd) begin
         rd_len_out = len_ff;
         rd_id_out  = id_ff;
      end else begin
         rd_len_out = rd_len_ff;
         rd_id_out  = rd_id_ff;
      end
   end

   assign own_len = len_ff;
   assign own_id  = id_ff;

endmodule
